### src/fppm_pkg.sv
// Shared types and constants of the flow pulse plausibility monitor.
package fppm_pkg;

   localparam int unsigned TIME_W      = 32;
   localparam int unsigned FLOW_W      = 20;
   localparam int unsigned COUNT_W     = 8;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned REQ_DATA_W  = 88;
   localparam int unsigned RSP_DATA_W  = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_MS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FLOW     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAULT_THRESH = 2'd2;

   localparam logic [TIME_W-1:0]  TIMEOUT_RESET  = 32'd10000;
   localparam logic [FLOW_W-1:0]  MAX_FLOW_RESET = 20'hFFFFF;
   localparam logic [COUNT_W-1:0] THRESH_RESET   = 8'd3;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'hFF;

   typedef enum logic [1:0] {
      CAUSE_NONE       = 2'd0,
      CAUSE_OVER_RATE  = 2'd1,
      CAUSE_INACTIVITY = 2'd2
   } cause_type;

   typedef struct packed {
      logic [TIME_W-1:0]  timeout_ms;
      logic [FLOW_W-1:0]  max_flow;
      logic [COUNT_W-1:0] fault_count_threshold;
   } cfg_type;

   typedef struct packed {
      logic               level;
      logic [TIME_W-1:0]  last_edge_ms;
      logic               fault;
      cause_type          kind;
      logic [COUNT_W-1:0] count;
   } state_type;

   typedef struct packed {
      logic               pulse_level;
      logic [TIME_W-1:0]  now_ms;
      logic [FLOW_W-1:0]  flow_value;
      logic [TIME_W-1:0]  flow_active_since_ms;
   } item_type;

endpackage

### src/fppm_csr_regs.sv
// Configuration registers of the monitor, written through the csr channel.
module fppm_csr_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fppm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fppm_pkg::CSR_DATA_W-1:0]   csr_data,
   output fppm_pkg::cfg_type                 cfg
);
   import fppm_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TIMEOUT_MS:   cfg_in.timeout_ms = csr_data;
            CSR_MAX_FLOW:     cfg_in.max_flow = csr_data[FLOW_W-1:0];
            CSR_FAULT_THRESH: cfg_in.fault_count_threshold = csr_data[COUNT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms            <= TIMEOUT_RESET;
         cfg_ff.max_flow              <= MAX_FLOW_RESET;
         cfg_ff.fault_count_threshold <= THRESH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/fppm_tick_logic.sv
// Next-state logic for one tick: edge tracking, over-rate and inactivity checks.
module fppm_tick_logic (
   input  fppm_pkg::item_type  item,
   input  fppm_pkg::cfg_type   cfg,
   input  fppm_pkg::state_type state_cur,
   output fppm_pkg::state_type state_next,
   output logic                edge_seen
);
   import fppm_pkg::*;

   logic              over_rate;
   logic [TIME_W-1:0] from_ms;
   logic [TIME_W-1:0] elapsed_ms;
   logic [TIME_W-1:0] edge_ms;
   logic              fault_mid;

   always_comb begin
      edge_seen  = item.pulse_level != state_cur.level;
      over_rate  = item.flow_value > cfg.max_flow;
      edge_ms    = edge_seen ? item.now_ms : state_cur.last_edge_ms;
      // Plain unsigned pick of the later start time; only the difference wraps.
      from_ms    = (item.flow_active_since_ms < edge_ms) ? edge_ms
                                                         : item.flow_active_since_ms;
      elapsed_ms = item.now_ms - from_ms;

      state_next              = state_cur;
      state_next.level        = item.pulse_level;
      state_next.last_edge_ms = edge_ms;

      fault_mid = state_cur.fault;
      if (edge_seen && !state_cur.fault && over_rate) begin
         fault_mid             = 1'b1;
         state_next.fault      = 1'b1;
         state_next.kind       = CAUSE_OVER_RATE;
      end

      if (!fault_mid && (item.flow_value != '0)) begin
         if (elapsed_ms > cfg.timeout_ms) begin
            if (state_cur.count != COUNT_MAX) begin
               state_next.count = state_cur.count + 1'b1;
            end
            if (state_next.count >= cfg.fault_count_threshold) begin
               state_next.fault = 1'b1;
               state_next.kind  = CAUSE_INACTIVITY;
            end
         end else begin
            state_next.count = '0;
         end
      end
   end

endmodule

### src/flow_pulse_plausibility_monitor.sv
// Flow pulse plausibility monitor: request register, tick logic, state and response register.
// A request is held in the request register until its tick passes into the response register,
// which drives rsp_tvalid. Throughput: one request per cycle while the response register is
// empty or taken; the tick state is updated in one step between the two registers.
// Reset clears the tick state and both valid flags and loads the register defaults;
// configuration writes take effect on the next tick.
module flow_pulse_plausibility_monitor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pulse_level[0], now_ms[32:1], flow_value[52:33], flow_active_since_ms[84:53], zeros
   input  logic [fppm_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // published_level[0], edge_seen[1], fault_latched[2], fault_cause[4:3],
   // inactivity_count[12:5], zeros
   output logic [fppm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fppm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fppm_pkg::CSR_DATA_W-1:0]   csr_data
);
   import fppm_pkg::*;

   cfg_type   cfg;
   item_type  item_ff, item_in;
   logic      in_valid_ff, in_valid_in;
   state_type state_ff, state_in, state_next;
   logic      edge_seen;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic      advance;
   logic      req_take;

   fppm_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fppm_tick_logic u_tick (
      .item       (item_ff),
      .cfg        (cfg),
      .state_cur  (state_ff),
      .state_next (state_next),
      .edge_seen  (edge_seen)
   );

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      item_in.pulse_level          = req_tdata[0];
      item_in.now_ms               = req_tdata[32:1];
      item_in.flow_value           = req_tdata[52:33];
      item_in.flow_active_since_ms = req_tdata[84:53];

      in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      state_in    = advance ? state_next : state_ff;

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_data_in = advance ? {3'b000, state_next.count, state_next.kind,
                               state_next.fault, edge_seen, state_next.level}
                            : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // A fault cause is recorded exactly when the fault is latched.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.fault == (state_ff.kind != CAUSE_NONE))
      else $error("fault flag and cause disagree");

   // Once latched, the fault stays until reset.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.fault |=> state_ff.fault)
      else $error("latched fault cleared");

   // Tick state only moves when a request passes into the response register.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("tick state changed without a request");

   // The request side only stalls while a request is held behind a full response.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("request side stalled without cause");

endmodule
